### rtl/stcb_pkg.sv
// ----------------------------------------------------------------------------
// Scrolling text console buffer package
// Shared operation codes, character constants, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package stcb_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int LINES_DEF   = 8;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_SETPOS = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
        logic sweep;
        logic init;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic scroll_req;
        logic sweep_last;
        logic init_last;
    } status_t;

endpackage

### rtl/stcb_ctrl.sv
// ----------------------------------------------------------------------------
// Scrolling text console buffer controller
// Sequences the start-up clear, one transaction's execution, the cell read
// and the line clear of a scroll, and marks the result with a strobe.
// ----------------------------------------------------------------------------
module stcb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  stcb_pkg::status_t status,
    output stcb_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);
    import stcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.op == OP_SETPOS || status.op == OP_READ)
                begin
                    state_next = ST_READ;
                end
                else if (status.scroll_req)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

### rtl/stcb_datapath.sv
// ----------------------------------------------------------------------------
// Scrolling text console buffer datapath
// Holds the character store, the cursor, the ring offset of the top line,
// the sweep counter for clearing and the result registers.
// ----------------------------------------------------------------------------
module stcb_datapath #(
    parameter int COLUMNS = stcb_pkg::COLUMNS_DEF,
    parameter int LINES   = stcb_pkg::LINES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stcb_pkg::cmd_t    cmd,
    output stcb_pkg::status_t status,
    input  logic [1:0]        operation,
    input  logic [7:0]        char_code,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    output logic [3:0]        cell_col,
    output logic [2:0]        cell_row,
    output logic [7:0]        cell_char,
    output logic              cell_written,
    output logic              scrolled,
    output logic [3:0]        cursor_col,
    output logic [2:0]        cursor_row
);
    import stcb_pkg::*;

    localparam int TOTAL = COLUMNS * LINES;
    localparam int CW    = $clog2(COLUMNS);
    localparam int LW    = $clog2(LINES);
    localparam int AW    = $clog2(TOTAL);

    localparam logic [7:0]    COL_MAX8 = 8'(COLUMNS - 1);
    localparam logic [7:0]    ROW_MAX8 = 8'(LINES - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [LW-1:0] ROW_LAST = LW'(LINES - 1);

    logic [7:0] mem [TOTAL];

    op_t           op_reg;
    logic [7:0]    char_reg;
    logic [CW-1:0] col_reg;
    logic [LW-1:0] row_reg;
    logic [CW-1:0] cur_col_reg;
    logic [LW-1:0] cur_row_reg;
    logic [LW-1:0] top_reg;
    logic [AW-1:0] sweep_cnt_reg;
    logic [CW-1:0] res_col_reg;
    logic [LW-1:0] res_row_reg;
    logic [7:0]    res_char_reg;
    logic          res_written_reg;
    logic          res_scrolled_reg;
    logic [7:0]    rd_data_reg;

    logic [7:0]    col_clamp;
    logic [7:0]    row_clamp;
    logic          is_newline;
    logic          last_row;
    logic          last_col;
    logic [LW-1:0] vis_line;
    logic [CW-1:0] vis_col;
    logic [LW:0]   line_sum;
    logic [LW-1:0] phys_line;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] clear_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [7:0]    col_ext;
    logic [7:0]    row_ext;
    logic [7:0]    cur_col_ext;
    logic [7:0]    cur_row_ext;

    assign col_clamp  = (col > COL_MAX8) ? COL_MAX8 : col;
    assign row_clamp  = (row > ROW_MAX8) ? ROW_MAX8 : row;
    assign is_newline = (char_reg == CHAR_NEWLINE);
    assign last_row   = (cur_row_reg == ROW_LAST);
    assign last_col   = (cur_col_reg == COL_LAST);

    assign vis_line  = (op_reg == OP_PUT) ? cur_row_reg : row_reg;
    assign vis_col   = (op_reg == OP_PUT) ? cur_col_reg : col_reg;
    assign line_sum  = {1'b0, vis_line} + {1'b0, top_reg};
    assign phys_line = (line_sum >= (LW+1)'(LINES)) ? LW'(line_sum - (LW+1)'(LINES))
                                                    : LW'(line_sum);
    assign cell_addr  = AW'(AW'(phys_line) * AW'(COLUMNS) + AW'(vis_col));
    assign clear_addr = AW'(AW'(top_reg) * AW'(COLUMNS) + sweep_cnt_reg);

    always_comb
    begin
        mem_addr  = cell_addr;
        mem_we    = 1'b0;
        mem_wdata = CHAR_SPACE;
        if (cmd.init)
        begin
            mem_addr = sweep_cnt_reg;
            mem_we   = 1'b1;
        end
        else if (cmd.sweep)
        begin
            mem_addr = clear_addr;
            mem_we   = 1'b1;
        end
        else if (cmd.exec && op_reg == OP_PUT && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_wdata = char_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign status.op         = op_reg;
    assign status.scroll_req = (op_reg == OP_PUT) && last_row && (is_newline || last_col);
    assign status.sweep_last = (sweep_cnt_reg == AW'(COLUMNS - 1));
    assign status.init_last  = (sweep_cnt_reg == AW'(TOTAL - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            sweep_cnt_reg <= '0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            if (cmd.init)
            begin
                sweep_cnt_reg <= AW'(sweep_cnt_reg + 1'b1);
            end
            if (cmd.load)
            begin
                op_reg        <= op_t'(operation);
                sweep_cnt_reg <= '0;
            end
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (is_newline || last_col)
                        begin
                            cur_col_reg <= '0;
                            if (!last_row)
                            begin
                                cur_row_reg <= LW'(cur_row_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            cur_col_reg <= CW'(cur_col_reg + 1'b1);
                        end
                    end
                    OP_SETPOS:
                    begin
                        cur_col_reg <= col_reg;
                        cur_row_reg <= row_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= AW'(sweep_cnt_reg + 1'b1);
                if (status.sweep_last)
                begin
                    top_reg <= (top_reg == ROW_LAST) ? '0 : LW'(top_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg         <= char_code;
            col_reg          <= col_clamp[CW-1:0];
            row_reg          <= row_clamp[LW-1:0];
            res_scrolled_reg <= 1'b0;
        end
        if (cmd.exec)
        begin
            res_col_reg     <= '0;
            res_row_reg     <= '0;
            res_char_reg    <= '0;
            res_written_reg <= 1'b0;
            case (op_reg)
                OP_PUT:
                begin
                    if (!is_newline)
                    begin
                        res_col_reg     <= cur_col_reg;
                        res_row_reg     <= cur_row_reg;
                        res_char_reg    <= char_reg;
                        res_written_reg <= 1'b1;
                    end
                end
                OP_SETPOS, OP_READ:
                begin
                    res_col_reg <= col_reg;
                    res_row_reg <= row_reg;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.capture)
        begin
            res_char_reg <= rd_data_reg;
        end
        if (cmd.sweep && status.sweep_last)
        begin
            res_scrolled_reg <= 1'b1;
        end
    end

    assign col_ext     = 8'(res_col_reg);
    assign row_ext     = 8'(res_row_reg);
    assign cur_col_ext = 8'(cur_col_reg);
    assign cur_row_ext = 8'(cur_row_reg);

    assign cell_col     = col_ext[3:0];
    assign cell_row     = row_ext[2:0];
    assign cell_char    = res_char_reg;
    assign cell_written = res_written_reg;
    assign scrolled     = res_scrolled_reg;
    assign cursor_col   = cur_col_ext[3:0];
    assign cursor_row   = cur_row_ext[2:0];

endmodule

### rtl/scrolling_text_console_buffer_top.sv
// ----------------------------------------------------------------------------
// Scrolling text console buffer
// Character grid with a cursor, line wrap and ring-offset scrolling, built
// as a controller and a datapath around a single-port character store.
//
//   Channel   Handshake            Payload
//   command   start / busy         operation, char_code, col, row
//   result    done (strobe)        cell_col, cell_row, cell_char, cell_written,
//                                  scrolled, cursor_col, cursor_row
//
// A put or an unused code goes through the execute and done states before
// the next acceptance; set cursor and read also pass the read state, for the
// registered store read. A scroll adds the clear state, one store write per
// cell of the cleared line. After reset, busy stays high while the store is
// cleared to spaces. The result is shown for one cycle and is not held.
// ----------------------------------------------------------------------------
module scrolling_text_console_buffer_top #(
    parameter int COLUMNS = stcb_pkg::COLUMNS_DEF,
    parameter int LINES   = stcb_pkg::LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [7:0] col,
    input  logic [7:0] row,
    output logic       done,
    output logic [3:0] cell_col,
    output logic [2:0] cell_row,
    output logic [7:0] cell_char,
    output logic       cell_written,
    output logic       scrolled,
    output logic [3:0] cursor_col,
    output logic [2:0] cursor_row
);
    import stcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    stcb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    stcb_datapath #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .cell_char    (cell_char),
        .cell_written (cell_written),
        .scrolled     (scrolled),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row)
    );

    // An accepted transaction never completes in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not keep the block busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while ready for a new transaction");

    // A scroll only happens from the bottom line, where the cursor stays.
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_row == 3'(LINES - 1) && cursor_col == 4'd0))
        else $error("scroll left the cursor off the start of the bottom line");

endmodule

### tb/sv/stcb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling text console buffer checker
// Watches the command and result channels of the console buffer. Every
// accepted command transaction is run through a cycle-free model of the
// character grid, cursor and scroll offset, and the predicted cell and cursor
// report is queued. Every result strobe is compared field by field with the
// oldest queued report. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module stcb_checker #(
    parameter int COLUMNS = stcb_pkg::COLUMNS_DEF,
    parameter int LINES   = stcb_pkg::LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [7:0] col,
    input  logic [7:0] row,
    input  logic       done,
    input  logic [3:0] cell_col,
    input  logic [2:0] cell_row,
    input  logic [7:0] cell_char,
    input  logic       cell_written,
    input  logic       scrolled,
    input  logic [3:0] cursor_col,
    input  logic [2:0] cursor_row,
    output int         errors,
    output int         pending,
    output int         results_seen,
    output int         scroll_count,
    output int         write_count
);

    import stcb_pkg::*;

    typedef struct packed {
        logic [3:0] cell_col;
        logic [2:0] cell_row;
        logic [7:0] cell_char;
        logic       cell_written;
        logic       scrolled;
        logic [3:0] cursor_col;
        logic [2:0] cursor_row;
    } cell_report_t;

    logic [7:0]   grid [LINES*COLUMNS];
    logic [3:0]   cur_col;
    logic [2:0]   cur_line;
    logic [2:0]   top_line;
    cell_report_t expected_reports [$];
    int           fail_count;
    int           result_count;
    int           scrolls;
    int           writes;

    function automatic int cell_index(input logic [2:0] vis_line, input logic [3:0] c);
        return ((int'(vis_line) + int'(top_line)) % LINES) * COLUMNS + int'(c);
    endfunction

    function automatic string describe(input cell_report_t rep);
        return $sformatf("cell=(%0d,%0d) char=%02h written=%0b scrolled=%0b cursor=(%0d,%0d)",
                         rep.cell_col, rep.cell_row, rep.cell_char, rep.cell_written,
                         rep.scrolled, rep.cursor_col, rep.cursor_row);
    endfunction

    task automatic line_feed(output logic did_scroll);
        cur_col = '0;
        if (int'(cur_line) < LINES - 1) begin
            cur_line   = cur_line + 3'd1;
            did_scroll = 1'b0;
        end else begin
            for (int i = 0; i < COLUMNS; i++) begin
                grid[int'(top_line) * COLUMNS + i] = CHAR_SPACE;
            end
            top_line   = 3'((int'(top_line) + 1) % LINES);
            cur_line   = 3'(LINES - 1);
            did_scroll = 1'b1;
        end
    endtask

    task automatic console_apply(input op_t op, input logic [7:0] ch, input logic [7:0] c8,
                                 input logic [7:0] r8, output cell_report_t rep);
        logic [3:0] c;
        logic [2:0] r;
        logic       did_scroll;
        rep        = '0;
        did_scroll = 1'b0;
        c = (int'(c8) > COLUMNS - 1) ? 4'(COLUMNS - 1) : c8[3:0];
        r = (int'(r8) > LINES - 1) ? 3'(LINES - 1) : r8[2:0];
        case (op)
            OP_PUT: begin
                if (ch == CHAR_NEWLINE) begin
                    line_feed(did_scroll);
                end else begin
                    grid[cell_index(cur_line, cur_col)] = ch;
                    rep.cell_col     = cur_col;
                    rep.cell_row     = cur_line;
                    rep.cell_char    = ch;
                    rep.cell_written = 1'b1;
                    if (int'(cur_col) == COLUMNS - 1) begin
                        line_feed(did_scroll);
                    end else begin
                        cur_col = cur_col + 4'd1;
                    end
                end
            end
            OP_SETPOS, OP_READ: begin
                if (op == OP_SETPOS) begin
                    cur_col  = c;
                    cur_line = r;
                end
                rep.cell_col  = c;
                rep.cell_row  = r;
                rep.cell_char = grid[cell_index(r, c)];
            end
            default: begin
            end
        endcase
        rep.scrolled   = did_scroll;
        rep.cursor_col = cur_col;
        rep.cursor_row = cur_line;
    endtask

    always @(posedge clk or negedge rst_n) begin
        cell_report_t actual;
        cell_report_t predicted;
        if (!rst_n) begin
            for (int i = 0; i < LINES * COLUMNS; i++) begin
                grid[i] = CHAR_SPACE;
            end
            cur_col      = '0;
            cur_line     = '0;
            top_line     = '0;
            fail_count   = 0;
            result_count = 0;
            scrolls      = 0;
            writes       = 0;
            expected_reports.delete();
        end else begin
            if (done) begin
                actual = '{cell_col, cell_row, cell_char, cell_written, scrolled,
                           cursor_col, cursor_row};
                result_count++;
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no transaction waiting: %s",
                                 $realtime, describe(actual));
                    end
                end else begin
                    predicted = expected_reports.pop_front();
                    if (actual !== predicted) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("    expected %s", describe(predicted));
                            $display("    actual   %s", describe(actual));
                        end
                    end
                end
            end
            if (start && !busy) begin
                console_apply(op_t'(operation), char_code, col, row, predicted);
                scrolls += predicted.scrolled;
                writes  += predicted.cell_written;
                expected_reports.push_back(predicted);
            end
        end
        errors       <= fail_count;
        pending      <= expected_reports.size();
        results_seen <= result_count;
        scroll_count <= scrolls;
        write_count  <= writes;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scrolling text console buffer testbench
// Drives directed and random command transactions into the console buffer
// with random idle bursts, and lets the checker predict and compare every
// result. Prints the verdict once all results have been accounted for.
// ----------------------------------------------------------------------------
module tb_top;

    import stcb_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 500000;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic [1:0] operation   = OP_NONE;
    logic [7:0] char_code   = '0;
    logic [7:0] col         = '0;
    logic [7:0] row         = '0;
    logic       busy;
    logic       done;
    logic [3:0] cell_col;
    logic [2:0] cell_row;
    logic [7:0] cell_char;
    logic       cell_written;
    logic       scrolled;
    logic [3:0] cursor_col;
    logic [2:0] cursor_row;
    int         errors;
    int         pending;
    int         results_seen;
    int         scroll_count;
    int         write_count;

    scrolling_text_console_buffer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .done         (done),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .cell_char    (cell_char),
        .cell_written (cell_written),
        .scrolled     (scrolled),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row)
    );

    stcb_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .done         (done),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .cell_char    (cell_char),
        .cell_written (cell_written),
        .scrolled     (scrolled),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .scroll_count (scroll_count),
        .write_count  (write_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    task automatic send_command(input op_t op, input logic [7:0] ch, input logic [7:0] c,
                                input logic [7:0] r);
        start     <= 1'b1;
        operation <= op;
        char_code <= ch;
        col       <= c;
        row       <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_position(input int limit, input int bottom_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return 8'($urandom_range(0, 255));
        if (roll < 25 + bottom_pct) return 8'(limit - 1);
        return 8'($urandom_range(0, limit - 1));
    endfunction

    task automatic send_random_command();
        int         roll;
        logic [7:0] ch;
        roll = $urandom_range(0, 99);
        ch   = ($urandom_range(0, 4) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
        if (roll < 58) begin
            send_command(OP_PUT, ch, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (roll < 74) begin
            send_command(OP_SETPOS, 8'($urandom_range(0, 255)),
                         pick_position(COLUMNS_DEF, 25), pick_position(LINES_DEF, 40));
        end else if (roll < 94) begin
            send_command(OP_READ, 8'($urandom_range(0, 255)),
                         pick_position(COLUMNS_DEF, 10), pick_position(LINES_DEF, 10));
        end else begin
            send_command(OP_NONE, ch, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int idle_pct;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(OP_PUT,    8'h48,        8'd0,   8'd0);
        send_command(OP_PUT,    8'h00,        8'd0,   8'd0);
        send_command(OP_PUT,    8'hFF,        8'd255, 8'd255);
        send_command(OP_READ,   8'h00,        8'd0,   8'd0);
        send_command(OP_READ,   8'hFF,        8'd255, 8'd255);
        send_command(OP_PUT,    CHAR_NEWLINE, 8'd0,   8'd0);
        send_command(OP_PUT,    8'h09,        8'd0,   8'd0);
        send_command(OP_PUT,    8'h0B,        8'd0,   8'd0);
        send_command(OP_SETPOS, 8'h00,        8'd255, 8'd255);
        idle_burst(5);
        send_command(OP_PUT,    8'hAA,        8'd0,   8'd0);
        send_command(OP_READ,   8'h00,        8'd1,   8'd6);
        send_command(OP_SETPOS, 8'h00,        8'd0,   8'd7);
        send_command(OP_PUT,    CHAR_NEWLINE, 8'd0,   8'd0);
        send_command(OP_PUT,    CHAR_NEWLINE, 8'd0,   8'd0);
        send_command(OP_SETPOS, 8'h00,        8'd15,  8'd3);
        send_command(OP_PUT,    8'h55,        8'd0,   8'd0);
        send_command(OP_NONE,   8'hFF,        8'd255, 8'd255);
        send_command(OP_SETPOS, 8'h00,        8'd16,  8'd8);
        send_command(OP_READ,   8'h00,        8'd15,  8'd0);
        send_command(OP_PUT,    CHAR_SPACE,   8'd0,   8'd0);
        send_command(OP_READ,   8'h00,        8'd128, 8'd4);
        send_command(OP_SETPOS, 8'h00,        8'd7,   8'd128);
        send_command(OP_NONE,   8'h00,        8'd0,   8'd0);
        idle_burst(2);

        idle_pct = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            end
            send_random_command();
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < idle_pct) begin
                idle_burst($urandom_range(1, 16));
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (4 * COLUMNS_DEF + 8) @(posedge clk);

        $display("Ran %0d command transactions: %0d cell writes, %0d scrolls.",
                 results_seen, write_count, scroll_count);
        $display("Mismatches and stray results: %0d, results still owed: %0d.",
                 errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### scrolling_text_console_buffer_top.f
rtl/stcb_pkg.sv
rtl/stcb_ctrl.sv
rtl/stcb_datapath.sv
rtl/scrolling_text_console_buffer_top.sv
tb/sv/stcb_checker.sv
tb/sv/tb_top.sv
